### rtl/rtcc_pkg.sv
// ----------------------------------------------------------------------------
// rtcc_pkg
// Shared types, limits and the month length table for the time of day
// calendar counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcc_pkg;

  // Item operation codes; the fourth code is unused and changes nothing
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_TIME = 2'd1,
    OP_SET_DATE = 2'd2
  } rtcc_op_e;

  // One input item as held in the input register
  typedef struct packed {
    rtcc_op_e    op;
    logic [4:0]  new_hours;
    logic [5:0]  new_minutes;
    logic [5:0]  new_seconds;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [13:0] new_year;
  } rtcc_item_t;

  // Full time and date
  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } rtcc_time_t;

  // Per-item result flags
  typedef struct packed {
    logic day_advanced;
    logic set_error;
  } rtcc_flags_t;

  // Field limits
  localparam logic [5:0]  SEC_MAX       = 6'd59;
  localparam logic [5:0]  MIN_MAX       = 6'd59;
  localparam logic [4:0]  HRS_MAX       = 5'd23;
  localparam logic [3:0]  MON_FIRST     = 4'd1;
  localparam logic [3:0]  MON_FEB       = 4'd2;
  localparam logic [3:0]  MON_MAX       = 4'd12;
  localparam logic [4:0]  DAY_FIRST     = 5'd1;
  localparam logic [4:0]  DAYS_FEB_LEAP = 5'd29;
  localparam logic [13:0] YEAR_MAX      = 14'd9999;

  // Divisibility by 25: y is a multiple of 25 exactly when (y * 25^-1 mod 2^14)
  // does not exceed floor((2^14 - 1) / 25)
  localparam logic [13:0] INV25_MOD14 = 14'd7209;
  localparam logic [13:0] DIV25_LIM   = 14'd655;

  // State after reset: 00:00:00, 1 January 2000
  localparam rtcc_time_t TIME_RESET = '{
    seconds: 6'd0,
    minutes: 6'd0,
    hours:   5'd0,
    day:     5'd1,
    month:   4'd1,
    year:    14'd2000
  };

  // Days per month in a common year, indexed by month; unused codes give 0
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
  };

  function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                               input logic       leap);
    logic [4:0] days;
    days = MONTH_LEN[month];
    if ((month == MON_FEB) && leap) begin
      days = DAYS_FEB_LEAP;
    end
    return days;
  endfunction

endpackage

`default_nettype wire

### rtl/rtcc_step.sv
// ----------------------------------------------------------------------------
// rtcc_step
// Next time and date for one item: tick with second to year carries, or a
// checked load of time or date. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcc_step (
  input  rtcc_pkg::rtcc_item_t  item_i,
  input  rtcc_pkg::rtcc_time_t  cur_i,
  output rtcc_pkg::rtcc_time_t  nxt_o,
  output rtcc_pkg::rtcc_flags_t flags_o
);
  import rtcc_pkg::*;

  logic        set_date;
  logic [13:0] year_chk;
  logic [3:0]  month_chk;
  logic [13:0] year_prod;
  logic        div4;
  logic        div16;
  logic        div25;
  logic        leap;
  logic [4:0]  month_days;
  logic        time_bad;
  logic        date_bad;

  // Leap check and month length are shared between tick and set date
  assign set_date  = (item_i.op == OP_SET_DATE);
  assign year_chk  = set_date ? item_i.new_year  : cur_i.year;
  assign month_chk = set_date ? item_i.new_month : cur_i.month;

  // only the low 14 bits of the product matter
  assign year_prod  = year_chk * INV25_MOD14;
  assign div4       = (year_chk[1:0] == 2'b00);
  assign div16      = (year_chk[3:0] == 4'b0000);
  assign div25      = (year_prod <= DIV25_LIM);
  // Century years are leap only when divisible by 400 (16 and 25)
  assign leap       = div4 && (!div25 || div16);
  assign month_days = days_in_month(month_chk, leap);

  // Validity of set requests
  assign time_bad = (item_i.new_hours > HRS_MAX) || (item_i.new_minutes > MIN_MAX) ||
                    (item_i.new_seconds > SEC_MAX);
  assign date_bad = (item_i.new_month < MON_FIRST) || (item_i.new_month > MON_MAX) ||
                    (item_i.new_year > YEAR_MAX) || (item_i.new_day < DAY_FIRST) ||
                    (item_i.new_day > month_days);

  // Next state
  always_comb begin
    nxt_o   = cur_i;
    flags_o = '0;
    unique case (item_i.op)
      OP_TICK: begin
        if (cur_i.seconds < SEC_MAX) begin
          nxt_o.seconds = cur_i.seconds + 6'd1;
        end else begin
          nxt_o.seconds = '0;
          if (cur_i.minutes < MIN_MAX) begin
            nxt_o.minutes = cur_i.minutes + 6'd1;
          end else begin
            nxt_o.minutes = '0;
            if (cur_i.hours < HRS_MAX) begin
              nxt_o.hours = cur_i.hours + 5'd1;
            end else begin
              // midnight: roll the date
              nxt_o.hours          = '0;
              flags_o.day_advanced = 1'b1;
              if (cur_i.day < month_days) begin
                nxt_o.day = cur_i.day + 5'd1;
              end else begin
                nxt_o.day = DAY_FIRST;
                if (cur_i.month < MON_MAX) begin
                  nxt_o.month = cur_i.month + 4'd1;
                end else begin
                  nxt_o.month = MON_FIRST;
                  // year saturates at the top
                  if (cur_i.year < YEAR_MAX) begin
                    nxt_o.year = cur_i.year + 14'd1;
                  end
                end
              end
            end
          end
        end
      end
      OP_SET_TIME: begin
        if (time_bad) begin
          flags_o.set_error = 1'b1;
        end else begin
          nxt_o.hours   = item_i.new_hours;
          nxt_o.minutes = item_i.new_minutes;
          nxt_o.seconds = item_i.new_seconds;
        end
      end
      OP_SET_DATE: begin
        if (date_bad) begin
          flags_o.set_error = 1'b1;
        end else begin
          nxt_o.day   = item_i.new_day;
          nxt_o.month = item_i.new_month;
          nxt_o.year  = item_i.new_year;
        end
      end
      default: begin
        // unused code: state held, no flags
        nxt_o   = cur_i;
        flags_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/time_of_day_calendar_counter.sv
// The input register takes an item at its transfer edge, and the result
// register takes its result from it whenever the result slot is free.
// Throughput: one item per cycle while out_ready_i holds; the whole update is
// one pass through the carry chain and a single 14-bit leap-year multiply.
// Reset: asynchronous, clears both valid flags and sets 00:00:00, 1 Jan 2000.
// ----------------------------------------------------------------------------
// time_of_day_calendar_counter
// Real-time clock and calendar driven by one-second ticks, with checked
// set-time and set-date requests. One result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module time_of_day_calendar_counter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // item channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [4:0]  new_hours_i,
  input  wire logic [5:0]  new_minutes_i,
  input  wire logic [5:0]  new_seconds_i,
  input  wire logic [4:0]  new_day_i,
  input  wire logic [3:0]  new_month_i,
  input  wire logic [13:0] new_year_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       cur_seconds_o,
  output logic [5:0]       cur_minutes_o,
  output logic [4:0]       cur_hours_o,
  output logic [4:0]       cur_day_o,
  output logic [3:0]       cur_month_o,
  output logic [13:0]      cur_year_o,
  output logic             day_advanced_o,
  output logic             set_error_o
);
  import rtcc_pkg::*;

  rtcc_item_t  item_d, item_q;
  logic        in_valid_q;
  logic        in_xfer;
  logic        out_free;
  logic        step_en;
  rtcc_time_t  time_d, time_q;
  rtcc_flags_t flags_d, flags_q;
  logic        out_valid_q;

  // Handshake: the input stage moves on whenever the result slot is free
  assign out_free   = !out_valid_q || out_ready_i;
  assign step_en    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Input item capture
  always_comb begin
    item_d.op          = rtcc_op_e'(op_i);
    item_d.new_hours   = new_hours_i;
    item_d.new_minutes = new_minutes_i;
    item_d.new_seconds = new_seconds_i;
    item_d.new_day     = new_day_i;
    item_d.new_month   = new_month_i;
    item_d.new_year    = new_year_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
  end

  // Next time and date
  rtcc_step u_step (
    .item_i  (item_q),
    .cur_i   (time_q),
    .nxt_o   (time_d),
    .flags_o (flags_d)
  );

  // Time and date registers double as the result payload: they change only
  // when a new result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= TIME_RESET;
    end else if (step_en) begin
      time_q <= time_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      flags_q <= flags_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cur_seconds_o  = time_q.seconds;
  assign cur_minutes_o  = time_q.minutes;
  assign cur_hours_o    = time_q.hours;
  assign cur_day_o      = time_q.day;
  assign cur_month_o    = time_q.month;
  assign cur_year_o     = time_q.year;
  assign day_advanced_o = flags_q.day_advanced;
  assign set_error_o    = flags_q.set_error;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An empty result slot never blocks the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result slot");

  // A midnight rollover leaves the time at 00:00:00
  a_rollover_midnight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && day_advanced_o) |->
      (cur_hours_o == 5'd0 && cur_minutes_o == 6'd0 && cur_seconds_o == 6'd0))
    else $error("day advanced but time not at midnight");

  // A result never carries both flags: day_advanced comes only from a tick, set_error only from a set
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(day_advanced_o && set_error_o))
    else $error("day_advanced and set_error both set");

  // Time and date stay within their ranges
  a_fields_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_seconds_o <= SEC_MAX) && (cur_minutes_o <= MIN_MAX) &&
    (cur_hours_o <= HRS_MAX) && (cur_month_o >= MON_FIRST) &&
    (cur_month_o <= MON_MAX) && (cur_day_o >= DAY_FIRST) &&
    (cur_year_o <= YEAR_MAX))
    else $error("time or date field out of range");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the time of day calendar counter. Ticks, set-time,
// set-date and unused-code transfers go in through a gapped driver; every
// result is checked against a cycle-free calendar model held in the bench,
// while the result side stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rtcc_pkg::*;

  // Fourth op code: changes nothing
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } clock_cmd_t;

  typedef struct {
    rtcc_time_t  now;
    rtcc_flags_t flags;
  } clock_reading_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i          = '0;
  logic [4:0]  new_hours_i   = '0;
  logic [5:0]  new_minutes_i = '0;
  logic [5:0]  new_seconds_i = '0;
  logic [4:0]  new_day_i     = '0;
  logic [3:0]  new_month_i   = '0;
  logic [13:0] new_year_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [5:0]  cur_seconds_o;
  logic [5:0]  cur_minutes_o;
  logic [4:0]  cur_hours_o;
  logic [4:0]  cur_day_o;
  logic [3:0]  cur_month_o;
  logic [13:0] cur_year_o;
  logic        day_advanced_o;
  logic        set_error_o;

  clock_cmd_t     cmd_queue[$];
  clock_reading_t readings_due[$];
  clock_cmd_t     cmd_on_bus;
  rtcc_time_t     tod;
  int             mismatches = 0;
  int             send_gap   = 0;
  int             recv_stall = 0;

  time_of_day_calendar_counter uut (.*);

  // Clock: 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calendar model
  // --------------------------------------------------------------------------
  function automatic bit leap_year(input logic [13:0] year);
    return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month,
                                            input logic [13:0] year);
    case (month)
      4'd2: begin
        return leap_year(year) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        return 5'd30;
      end
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
        return 5'd31;
      end
      default: begin
        return 5'd0;
      end
    endcase
  endfunction

  // Apply one command to the modelled clock and return what the block shows
  function automatic clock_reading_t advance_clock(input clock_cmd_t c);
    clock_reading_t r;
    r.flags = '0;
    case (c.op)
      OP_TICK: begin
        if (tod.seconds < SEC_MAX) begin
          tod.seconds++;
        end else begin
          tod.seconds = '0;
          if (tod.minutes < MIN_MAX) begin
            tod.minutes++;
          end else begin
            tod.minutes = '0;
            if (tod.hours < HRS_MAX) begin
              tod.hours++;
            end else begin
              // midnight: roll the date, year sticks at its maximum
              tod.hours = '0;
              r.flags.day_advanced = 1'b1;
              if (tod.day < month_days(tod.month, tod.year)) begin
                tod.day++;
              end else begin
                tod.day = DAY_FIRST;
                if (tod.month < MON_MAX) begin
                  tod.month++;
                end else begin
                  tod.month = MON_FIRST;
                  if (tod.year < YEAR_MAX) begin
                    tod.year++;
                  end
                end
              end
            end
          end
        end
      end
      OP_SET_TIME: begin
        if (c.hours > HRS_MAX || c.minutes > MIN_MAX || c.seconds > SEC_MAX) begin
          r.flags.set_error = 1'b1;
        end else begin
          tod.hours   = c.hours;
          tod.minutes = c.minutes;
          tod.seconds = c.seconds;
        end
      end
      OP_SET_DATE: begin
        if (c.month < MON_FIRST || c.month > MON_MAX || c.year > YEAR_MAX ||
            c.day < DAY_FIRST || c.day > month_days(c.month, c.year)) begin
          r.flags.set_error = 1'b1;
        end else begin
          tod.day   = c.day;
          tod.month = c.month;
          tod.year  = c.year;
        end
      end
      default: begin
      end
    endcase
    r.now = tod;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_cmd(input logic [1:0] op, input int h, input int mi,
                                    input int s, input int d, input int mo,
                                    input int y);
    clock_cmd_t c;
    c.op      = op;
    c.hours   = h[4:0];
    c.minutes = mi[5:0];
    c.seconds = s[5:0];
    c.day     = d[4:0];
    c.month   = mo[3:0];
    c.year    = y[13:0];
    cmd_queue = {cmd_queue, c};
  endfunction

  function automatic void queue_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      queue_cmd(OP_TICK, $urandom_range(0, 31), $urandom_range(0, 63),
                $urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 15),
                $urandom_range(0, 16383));
    end
  endfunction

  // Years around the leap rule edges, the saturation point, or anything
  function automatic int pick_year();
    int edge_years[9] = '{0, 100, 400, 1900, 2000, 2100, 2400, 9998, 9999};
    if ($urandom_range(0, 1) == 0) begin
      return edge_years[$urandom_range(0, 8)];
    end
    return $urandom_range(0, 9999);
  endfunction

  // A legal date, mostly on the last day of its month
  function automatic void queue_good_date();
    int mo;
    int y;
    int last;
    mo   = $urandom_range(1, 12);
    y    = pick_year();
    last = month_days(mo[3:0], y[13:0]);
    queue_cmd(OP_SET_DATE, $urandom_range(0, 31), $urandom_range(0, 63),
              $urandom_range(0, 63),
              ($urandom_range(0, 1) == 0) ? last : $urandom_range(1, last), mo, y);
  endfunction

  // Idle length: bursts with none, otherwise mostly short and a few long
  function automatic int pick_gap();
    int r;
    if ((($time / 20) / 300) % 3 == 0) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 30);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 60) begin
      $display("%0t ns: MISMATCH %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: holds each item until its transfer, then idles for a gap
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        readings_due = {readings_due, advance_clock(cmd_on_bus)};
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cmd_on_bus     = cmd_queue.pop_front();
          op_i          <= cmd_on_bus.op;
          new_hours_i   <= cmd_on_bus.hours;
          new_minutes_i <= cmd_on_bus.minutes;
          new_seconds_i <= cmd_on_bus.seconds;
          new_day_i     <= cmd_on_bus.day;
          new_month_i   <= cmd_on_bus.month;
          new_year_i    <= cmd_on_bus.year;
          in_valid_i    <= 1'b1;
          send_gap       = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transfer, stalls ready at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    clock_reading_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (readings_due.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = readings_due.pop_front();
          check_field("seconds", cur_seconds_o, want.now.seconds);
          check_field("minutes", cur_minutes_o, want.now.minutes);
          check_field("hours", cur_hours_o, want.now.hours);
          check_field("day", cur_day_o, want.now.day);
          check_field("month", cur_month_o, want.now.month);
          check_field("year", cur_year_o, want.now.year);
          check_field("day_advanced", day_advanced_o, want.flags.day_advanced);
          check_field("set_error", set_error_o, want.flags.set_error);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall   = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int target;
    int r;
    tod = TIME_RESET;

    // directed: reset state, carries, leap rules, bad fields, saturation
    queue_ticks(1);
    queue_cmd(OP_SET_TIME, 23, 59, 59, 0, 0, 0);
    queue_ticks(1);
    queue_cmd(OP_SET_TIME, 24, 0, 0, 0, 0, 0);
    queue_cmd(OP_SET_TIME, 0, 60, 0, 0, 0, 0);
    queue_cmd(OP_SET_TIME, 0, 0, 60, 0, 0, 0);
    queue_cmd(OP_SET_TIME, 31, 63, 63, 31, 15, 16383);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 29, 2, 2000);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 29, 2, 1900);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 29, 2, 0);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 0, 5, 2010);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 10, 0, 2010);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 10, 13, 2010);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 10, 15, 2010);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 10, 6, 10000);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 31, 4, 16383);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 28, 2, 2001);
    queue_cmd(OP_SET_TIME, 23, 59, 59, 0, 0, 0);
    queue_ticks(1);
    queue_cmd(OP_SET_DATE, 0, 0, 0, 31, 12, 9999);
    queue_cmd(OP_SET_TIME, 23, 59, 58, 0, 0, 0);
    queue_ticks(2);
    queue_cmd(OP_IDLE, 31, 63, 63, 31, 15, 16383);
    queue_cmd(OP_SET_TIME, 0, 0, 0, 0, 0, 0);

    // random: mostly midnight crossings from chosen dates, then noise
    target = cmd_queue.size() + RANDOM_ITEMS;
    while (cmd_queue.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if ($urandom_range(0, 3) != 0) begin
          queue_good_date();
        end
        queue_cmd(OP_SET_TIME, 23, 59, $urandom_range(55, 59), $urandom_range(0, 31),
                  $urandom_range(0, 15), $urandom_range(0, 16383));
        queue_ticks($urandom_range(1, 8));
      end else if (r < 58) begin
        queue_ticks($urandom_range(10, 70));
      end else if (r < 72) begin
        queue_cmd(OP_SET_TIME, $urandom_range(0, 23), $urandom_range(0, 59),
                  $urandom_range(0, 59), 0, 0, 0);
        queue_good_date();
      end else if (r < 92) begin
        queue_cmd($urandom_range(0, 1) ? OP_SET_TIME : OP_SET_DATE,
                  $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
      end else begin
        queue_cmd(OP_IDLE, $urandom_range(0, 31), $urandom_range(0, 63),
                  $urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 15),
                  $urandom_range(0, 16383));
      end
    end

    // hold reset, then release it away from the rising edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain
    while (cmd_queue.size() > 0 || in_valid_i || readings_due.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (readings_due.size() != 0) begin
      report_mismatch("results still outstanding at end of run");
    end

    if (mismatches == 0) begin
      $display("time_of_day_calendar_counter test passed");
    end else begin
      $display("time_of_day_calendar_counter test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("time_of_day_calendar_counter test failed");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/rtcc_pkg.sv
rtl/rtcc_step.sv
rtl/time_of_day_calendar_counter.sv
tb/sv/testbench.sv
